>>> hdl/srct_pkg.sv
`timescale 1ns / 1ps
// Package for the segment/rectangle crossing-time block.
// Shared widths, result codes and divider status; no dependencies.
package srct_pkg;

  localparam int unsigned COORD_W   = 14;
  localparam int unsigned TIME_W    = 31;
  localparam int unsigned DIFF_W    = 16;
  localparam int unsigned OPA_W     = 32;
  localparam int unsigned PROD_W    = 48;
  localparam int unsigned CROSS_W   = 34;
  localparam int unsigned DIV_NUM_W = 47;
  localparam int unsigned DIV_DEN_W = 15;
  localparam logic [TIME_W-1:0] TIME_MAX = 31'h7fffffff;

  // Result codes
  typedef enum logic [1:0] {
    OUT_NONE    = 2'd0,
    OUT_ONE     = 2'd1,
    OUT_IN_WIN  = 2'd2,
    OUT_OUT_WIN = 2'd3
  } outcome_e;

  // Register indexes
  typedef enum logic [2:0] {
    REG_RECT_LEFT   = 3'd0,
    REG_RECT_BOTTOM = 3'd1,
    REG_RECT_RIGHT  = 3'd2,
    REG_RECT_TOP    = 3'd3,
    REG_DWELL_MIN   = 3'd4,
    REG_DWELL_MAX   = 3'd5
  } reg_idx_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hdl/srct_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on srct_pkg for the status struct.
module srct_div #(
  parameter int unsigned NumW = 47,
  parameter int unsigned DenW = 15
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [NumW-1:0]         num_i,
  input  logic [DenW-1:0]         den_i,
  output srct_pkg::div_stat_t     stat_o,
  output logic [NumW-1:0]         quo_o
);
  import srct_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DenW-1:0] rem_q, rem_d, den_q;
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   shifted, trial;
  logic            qbit;

  // One trial subtraction per cycle
  always_comb begin
    shifted = {rem_q, quo_q[NumW-1]};
    trial   = shifted - {1'b0, den_q};
    qbit    = shifted >= {1'b0, den_q};
    rem_d   = qbit ? trial[DenW-1:0] : shifted[DenW-1:0];
  end

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CntW'(NumW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NumW-2:0], qbit};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

>>> hdl/segment_rect_crossing_time.sv
`timescale 1ns / 1ps
// Top level: segment versus rectangle crossing-time unit.
// Depends on srct_pkg and srct_div.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | input     | in_valid_i / in_ready_o | start_x/y, end_x/y, start/end_time
//  out     | output    | out_valid_o/out_ready_i | outcome, crossing_time, entered, exited
//  cfg     | input     | APB psel/penable/pready | six registers at byte address 4*i
//
// Each edge uses the one shared 32x16 multiplier (eight cross products, one
// time product), then the bit-serial divider when the edge is crossed, then
// a scan step. in_ready_o is high only while idle.
// A finished result waits in the output register while the next item is taken;
// a new result holds the block until that register is free.
// Reset clears the rectangle, the dwell window and the entered/left flags.
module segment_rect_crossing_time #(
  parameter int unsigned DivNumW = srct_pkg::DIV_NUM_W,
  parameter int unsigned DivDenW = srct_pkg::DIV_DEN_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [srct_pkg::COORD_W-1:0] start_x_i,
  input  logic signed [srct_pkg::COORD_W-1:0] start_y_i,
  input  logic signed [srct_pkg::COORD_W-1:0] end_x_i,
  input  logic signed [srct_pkg::COORD_W-1:0] end_y_i,
  input  logic [srct_pkg::TIME_W-1:0]         start_time_i,
  input  logic [srct_pkg::TIME_W-1:0]         end_time_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          outcome_o,
  output logic [srct_pkg::TIME_W-1:0]         crossing_time_o,
  output logic                                entered_o,
  output logic                                exited_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [4:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import srct_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_EVAL = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  localparam logic [3:0] SUB_LAST = 4'd9;

  state_e state_q, state_d;

  // Configuration
  logic signed [COORD_W-1:0] rect_left_q, rect_bottom_q, rect_right_q, rect_top_q;
  logic [TIME_W-1:0]         dwell_min_q, dwell_max_q;
  reg_idx_e                  cfg_idx;
  logic                      cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_left_q   <= '0;
      rect_bottom_q <= '0;
      rect_right_q  <= '0;
      rect_top_q    <= '0;
      dwell_min_q   <= '0;
      dwell_max_q   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RECT_LEFT:   rect_left_q   <= pwdata[COORD_W-1:0];
        REG_RECT_BOTTOM: rect_bottom_q <= pwdata[COORD_W-1:0];
        REG_RECT_RIGHT:  rect_right_q  <= pwdata[COORD_W-1:0];
        REG_RECT_TOP:    rect_top_q    <= pwdata[COORD_W-1:0];
        REG_DWELL_MIN:   dwell_min_q   <= pwdata[TIME_W-1:0];
        REG_DWELL_MAX:   dwell_max_q   <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_RECT_LEFT:   prdata = 32'({1'b0, rect_left_q});
      REG_RECT_BOTTOM: prdata = 32'({1'b0, rect_bottom_q});
      REG_RECT_RIGHT:  prdata = 32'({1'b0, rect_right_q});
      REG_RECT_TOP:    prdata = 32'({1'b0, rect_top_q});
      REG_DWELL_MIN:   prdata = 32'(dwell_min_q);
      REG_DWELL_MAX:   prdata = 32'(dwell_max_q);
      default:         prdata = '0;
    endcase
  end

  // Item registers and sequencer state
  logic signed [COORD_W-1:0] cx_q, cy_q, dx_q, dy_q;
  logic [TIME_W-1:0]         t1_q, t2_q;
  logic [1:0]                edge_q;
  logic [3:0]                sub_q;
  logic                      have_q, ep_q;
  outcome_e                  res_q;
  logic [TIME_W-1:0]         et_q, first_q;
  logic                      entered_q, exited_q;
  logic                      out_valid_q;
  outcome_e                  out_outcome_q;
  logic [TIME_W-1:0]         out_time_q;
  logic                      out_entered_q, out_exited_q;

  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Edge endpoints: bottom, right, top, left
  logic signed [COORD_W-1:0] ax, ay, bx, by;
  always_comb begin
    case (edge_q)
      2'd0: begin
        ax = rect_left_q;  ay = rect_bottom_q; bx = rect_right_q; by = rect_bottom_q;
      end
      2'd1: begin
        ax = rect_right_q; ay = rect_bottom_q; bx = rect_right_q; by = rect_top_q;
      end
      2'd2: begin
        ax = rect_left_q;  ay = rect_top_q;    bx = rect_right_q; by = rect_top_q;
      end
      default: begin
        ax = rect_left_q;  ay = rect_bottom_q; bx = rect_left_q;  by = rect_top_q;
      end
    endcase
  end

  // Coordinate differences
  logic signed [DIFF_W-1:0] bx_ax, by_ay, cx_ax, cy_ay, dx_ax, dy_ay;
  logic signed [DIFF_W-1:0] dx_cx, dy_cy, ax_cx, ay_cy, bx_cx, by_cy;
  assign bx_ax = DIFF_W'(bx) - DIFF_W'(ax);
  assign by_ay = DIFF_W'(by) - DIFF_W'(ay);
  assign cx_ax = DIFF_W'(cx_q) - DIFF_W'(ax);
  assign cy_ay = DIFF_W'(cy_q) - DIFF_W'(ay);
  assign dx_ax = DIFF_W'(dx_q) - DIFF_W'(ax);
  assign dy_ay = DIFF_W'(dy_q) - DIFF_W'(ay);
  assign dx_cx = DIFF_W'(dx_q) - DIFF_W'(cx_q);
  assign dy_cy = DIFF_W'(dy_q) - DIFF_W'(cy_q);
  assign ax_cx = DIFF_W'(ax) - DIFF_W'(cx_q);
  assign ay_cy = DIFF_W'(ay) - DIFF_W'(cy_q);
  assign bx_cx = DIFF_W'(bx) - DIFF_W'(cx_q);
  assign by_cy = DIFF_W'(by) - DIFF_W'(cy_q);

  // Interpolation axis: along x for a vertical edge, else along y
  logic use_x, use_int;
  assign use_x   = (ax == bx) && (cx_q != dx_q);
  assign use_int = use_x || ((ay == by) && (cy_q != dy_q));

  logic signed [OPA_W-1:0] dt;
  assign dt = $signed(OPA_W'(t2_q)) - $signed(OPA_W'(t1_q));

  // Shared multiplier operand select
  logic signed [OPA_W-1:0]  op_a;
  logic signed [DIFF_W-1:0] op_b;
  always_comb begin
    case (sub_q)
      4'd0:    begin op_a = OPA_W'(bx_ax); op_b = cy_ay; end
      4'd1:    begin op_a = OPA_W'(by_ay); op_b = cx_ax; end
      4'd2:    begin op_a = OPA_W'(bx_ax); op_b = dy_ay; end
      4'd3:    begin op_a = OPA_W'(by_ay); op_b = dx_ax; end
      4'd4:    begin op_a = OPA_W'(dx_cx); op_b = ay_cy; end
      4'd5:    begin op_a = OPA_W'(dy_cy); op_b = ax_cx; end
      4'd6:    begin op_a = OPA_W'(dx_cx); op_b = by_cy; end
      4'd7:    begin op_a = OPA_W'(dy_cy); op_b = bx_cx; end
      4'd8:    begin op_a = dt;            op_b = use_x ? ax_cx : ay_cy; end
      default: begin op_a = '0;            op_b = '0; end
    endcase
  end

  logic signed [PROD_W-1:0]  mul_res, prod_q, hold_q;
  logic signed [CROSS_W-1:0] cross_v;
  logic [3:0][1:0]           sgn_q;
  logic [1:0]                sgn_idx;
  logic                      cross_ok, qneg_q;
  assign mul_res  = PROD_W'(op_a) * PROD_W'(op_b);
  assign cross_v  = CROSS_W'(hold_q) - CROSS_W'(prod_q);
  assign sgn_idx  = 2'(sub_q[3:1] - 3'd1);
  assign cross_ok = (sgn_q[0] != sgn_q[1]) && (sgn_q[2] != sgn_q[3]);

  // Divider operands: magnitudes of the time product and the extent
  logic signed [DIFF_W-1:0] den_s;
  logic [PROD_W-1:0]        num_abs;
  logic [DIFF_W-1:0]        den_abs;
  logic                     div_start;
  div_stat_t                div_stat;
  logic [DivNumW-1:0]       quo;
  assign den_s     = use_x ? dx_cx : dy_cy;
  assign num_abs   = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign den_abs   = den_s[DIFF_W-1] ? DIFF_W'(-den_s) : DIFF_W'(den_s);
  assign div_start = (state_q == S_MUL) && (sub_q == SUB_LAST) && cross_ok && use_int;

  srct_div #(
    .NumW (DivNumW),
    .DenW (DivDenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (DivNumW'(num_abs)),
    .den_i   (DivDenW'(den_abs)),
    .stat_o  (div_stat),
    .quo_o   (quo)
  );

  // Crossing time: start time plus signed quotient, limited to the time range
  localparam int unsigned RW = DivNumW + 2;
  logic signed [RW-1:0] q_s, r_s;
  logic                 r_pos, r_big;
  logic [TIME_W-1:0]    r_time;
  assign q_s    = qneg_q ? -$signed(RW'(quo)) : $signed(RW'(quo));
  assign r_s    = $signed(RW'(t1_q)) + q_s;
  assign r_pos  = !r_s[RW-1] && (r_s != '0);
  assign r_big  = |r_s[RW-2:TIME_W];
  assign r_time = r_big ? TIME_MAX : r_s[TIME_W-1:0];

  // Scan step: gap between two different crossings
  logic [TIME_W-1:0] gap;
  logic              in_win, scan_stop;
  assign gap       = (first_q > et_q) ? (first_q - et_q) : (et_q - first_q);
  assign in_win    = (gap >= dwell_min_q) && (gap <= dwell_max_q);
  assign scan_stop = ep_q && have_q && (et_q != first_q);

  // Final result
  logic final_one, out_free;
  assign final_one = (res_q == OUT_NONE) && have_q;
  assign out_free  = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MUL;
      S_MUL:  if (sub_q == SUB_LAST) state_d = (cross_ok && use_int) ? S_DIV : S_EVAL;
      S_DIV:  if (div_stat.done) state_d = S_EVAL;
      S_EVAL: state_d = (scan_stop || edge_q == 2'd3) ? S_FIN : S_MUL;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sub_q       <= '0;
      edge_q      <= '0;
      have_q      <= 1'b0;
      ep_q        <= 1'b0;
      res_q       <= OUT_NONE;
      entered_q   <= 1'b0;
      exited_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_acc) begin
          sub_q  <= '0;
          edge_q <= '0;
          have_q <= 1'b0;
          res_q  <= OUT_NONE;
        end
        S_MUL: begin
          sub_q <= sub_q + 1'b1;
          if (sub_q == SUB_LAST) ep_q <= 1'b0;
        end
        S_DIV: if (div_stat.done) ep_q <= r_pos;
        S_EVAL: begin
          sub_q  <= '0;
          edge_q <= edge_q + 1'b1;
          if (ep_q) begin
            if (!have_q) have_q <= 1'b1;
            else if (et_q != first_q) res_q <= in_win ? OUT_IN_WIN : OUT_OUT_WIN;
          end
        end
        S_FIN: if (out_free) begin
          if (final_one) begin
            if (entered_q) exited_q <= 1'b1;
            else entered_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cx_q <= start_x_i;
      cy_q <= start_y_i;
      dx_q <= end_x_i;
      dy_q <= end_y_i;
      t1_q <= start_time_i;
      t2_q <= end_time_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= mul_res;
      if (sub_q[0]) hold_q <= prod_q;
      else if (sub_q != 4'd0) sgn_q[sgn_idx] <= {cross_v != '0, cross_v[CROSS_W-1]};
      if (sub_q == SUB_LAST) qneg_q <= prod_q[PROD_W-1] ^ den_s[DIFF_W-1];
    end
    if (state_q == S_DIV && div_stat.done) et_q <= r_time;
    if (state_q == S_EVAL && ep_q && !have_q) first_q <= et_q;
    if (state_q == S_FIN && out_free) begin
      out_outcome_q <= final_one ? OUT_ONE : res_q;
      out_time_q    <= final_one ? first_q : '0;
      out_entered_q <= entered_q | final_one;
      out_exited_q  <= exited_q | (final_one & entered_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign outcome_o       = out_outcome_q;
  assign crossing_time_o = out_time_q;
  assign entered_o       = out_entered_q;
  assign exited_o        = out_exited_q;

endmodule

>>> hdl/srct_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the crossing-time block, bound to the top level.
// Depends on srct_pkg for field widths.
module srct_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [1:0]                          outcome_o,
  input logic [srct_pkg::TIME_W-1:0]         crossing_time_o,
  input logic                                entered_o,
  input logic                                exited_o
);
  import srct_pkg::*;

  // An accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted item");

  // Time is reported only for a single crossing
  a_time_only_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o != OUT_ONE) |-> crossing_time_o == '0)
    else $error("crossing time set without a single crossing");

  // Left flag implies entered flag
  a_exit_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exited_o |-> entered_o)
    else $error("left flag without entered flag");

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(outcome_o))
    else $error("result dropped while stalled");

endmodule

bind segment_rect_crossing_time srct_chk u_srct_chk (.*);
